### hdl/olmc_pkg.sv
`timescale 1ns / 1ps

package olmc_pkg;

    // Default table depth
    localparam int CAPACITY_DEF = 64;

    // Command codes
    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_SELECT = 2'd2,
        KIND_CLEAR  = 2'd3
    } kind_t;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_EMPTY     = 2'd2,
        STAT_FULL      = 2'd3
    } status_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // One table slot, used bit kept apart
    typedef struct packed {
        logic [15:0] node;
        logic [15:0] fcost;
        logic [15:0] hcost;
        logic [31:0] age;
    } slot_data_t;

    // Control from the sequencer to the candidate picker
    typedef struct packed {
        logic  clr;
        kind_t mode;
    } scan_ctl_t;

endpackage

### hdl/olmc_store.sv
`timescale 1ns / 1ps

module olmc_store #(
    parameter int CAPACITY = olmc_pkg::CAPACITY_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // read port, registered data
    input  logic                        rd_en,
    input  logic [$clog2(CAPACITY)-1:0] rd_addr,
    output logic                        rd_vld,
    output logic [$clog2(CAPACITY)-1:0] rd_idx,
    output logic                        rd_used,
    output olmc_pkg::slot_data_t        rd_data,
    // write port
    input  logic                        wr_en,
    input  logic [$clog2(CAPACITY)-1:0] wr_addr,
    input  logic                        wr_used,
    input  logic                        wr_data_en,
    input  olmc_pkg::slot_data_t        wr_data
);
    import olmc_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    logic       used_mem [CAPACITY];
    slot_data_t data_mem [CAPACITY];

    logic          rd_vld_reg;
    logic [AW-1:0] rd_idx_reg;
    logic          rd_used_reg;
    slot_data_t    rd_data_reg;

    // Memory write; the used bit can be written without the payload
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            used_mem[wr_addr] <= wr_used;
            if (wr_data_en)
            begin
                data_mem[wr_addr] <= wr_data;
            end
        end
    end

    // Registered read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_used_reg <= used_mem[rd_addr];
            rd_data_reg <= data_mem[rd_addr];
            rd_idx_reg  <= rd_addr;
        end
    end

    // Read data valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= rd_en;
        end
    end

    assign rd_vld  = rd_vld_reg;
    assign rd_idx  = rd_idx_reg;
    assign rd_used = rd_used_reg;
    assign rd_data = rd_data_reg;

endmodule

### hdl/olmc_pick.sv
`timescale 1ns / 1ps

module olmc_pick #(
    parameter int CAPACITY = olmc_pkg::CAPACITY_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  olmc_pkg::scan_ctl_t         ctl,
    input  logic [15:0]                 key_id,
    input  logic [31:0]                 stamp,
    input  logic                        rd_vld,
    input  logic [$clog2(CAPACITY)-1:0] rd_idx,
    input  logic                        rd_used,
    input  olmc_pkg::slot_data_t        rd_data,
    output logic                        best_hit,
    output logic [$clog2(CAPACITY)-1:0] best_idx,
    output olmc_pkg::slot_data_t        best_data
);
    import olmc_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    logic          hit_reg;
    logic [AW-1:0] idx_reg;
    slot_data_t    data_reg;
    logic [31:0]   dist_reg;

    logic [31:0]   dist_now;
    logic          newer;
    logic          cost_win;
    logic          take;

    // Wrapped insert distance: smaller means more recent
    assign dist_now = stamp - rd_data.age;
    assign newer    = dist_now < dist_reg;

    // Least f, then least h, then most recent
    assign cost_win = (rd_data.fcost < data_reg.fcost) ||
                      ((rd_data.fcost == data_reg.fcost) &&
                       ((rd_data.hcost < data_reg.hcost) ||
                        ((rd_data.hcost == data_reg.hcost) && newer)));

    // Does the slot just read replace the current candidate
    always_comb
    begin
        unique case (ctl.mode)
            KIND_INSERT: take = !rd_used && !hit_reg;
            KIND_REMOVE: take = rd_used && (rd_data.node == key_id) && (!hit_reg || newer);
            KIND_SELECT: take = rd_used && (!hit_reg || cost_win);
            default:     take = 1'b0;
        endcase
    end

    // Candidate hit flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else if (ctl.clr)
        begin
            hit_reg <= 1'b0;
        end
        else if (rd_vld && take)
        begin
            hit_reg <= 1'b1;
        end
    end

    // Candidate payload
    always_ff @(posedge clk)
    begin
        if (rd_vld && take && !ctl.clr)
        begin
            idx_reg  <= rd_idx;
            data_reg <= rd_data;
            dist_reg <= dist_now;
        end
    end

    assign best_hit  = hit_reg;
    assign best_idx  = idx_reg;
    assign best_data = data_reg;

endmodule

### hdl/open_list_min_cost_table_unit.sv
`timescale 1ns / 1ps

// Bounded open list for best-first path search: CAPACITY slots of
// (node id, f cost, h cost), kept in one slot memory plus a used-bit memory.
// Command channel: a transfer happens at a rising edge with start high and
// busy low; kind selects insert, remove by id, select minimum or clear.
// Result channel: done is high for exactly one cycle with status, the found
// fields and entry_total; the receiver takes it that cycle and cannot stall.
// Sequence of each command, from the accepting edge to the result:
//   insert, remove, select: one full pass over the slot memory, one read
//     per cycle, then the registered read data and a write-back state.
//   insert into a full table, remove or select on an empty one: no pass.
//   clear: one used bit written per cycle, then the result.
// One command is in work at a time; busy stays high until its result is
// registered. A new command may be given in the cycle done is high.
// Reset: after rst_n rises the unit sweeps the whole used-bit memory with
// busy high and no result, then accepts commands.
module open_list_min_cost_table_unit #(
    parameter int CAPACITY = olmc_pkg::CAPACITY_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  kind,
    input  logic [15:0] node_id,
    input  logic [15:0] f_cost,
    input  logic [15:0] h_cost,
    output logic        done,
    output logic [1:0]  status,
    output logic [15:0] found_node,
    output logic [15:0] found_f_cost,
    output logic [15:0] found_h_cost,
    output logic [6:0]  entry_total
);
    import olmc_pkg::*;

    localparam int AW    = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int HW    = (CNT_W > 7) ? CNT_W : 7;

    state_t        state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [HW-1:0] held_reg;
    logic [31:0]   stamp_reg;
    logic          clr_resp_reg;

    kind_t         kind_reg;
    logic [15:0]   id_reg, f_reg, h_reg;

    logic          done_reg;
    status_t       status_reg;
    logic [15:0]   node_out_reg, f_out_reg, h_out_reg;

    logic          accept;
    kind_t         kind_in;
    logic          table_empty, table_full;
    logic          quick_resp;
    logic          clear_last;
    logic          scan_last;

    // memory and picker hookup
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          rd_vld;
    logic [AW-1:0] rd_idx;
    logic          rd_used;
    slot_data_t    rd_data;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          wr_used;
    logic          wr_data_en;
    slot_data_t    wr_data;
    scan_ctl_t     scan_ctl;
    logic          best_hit;
    logic [AW-1:0] best_idx;
    slot_data_t    best_data;

    // Command transfer and early answers
    assign busy        = (state_reg != ST_IDLE);
    assign accept      = start && !busy;
    assign kind_in     = kind_t'(kind);
    assign table_empty = (held_reg == '0);
    assign table_full  = (held_reg == HW'(CAPACITY));
    assign quick_resp  = accept &&
                         ((((kind_in == KIND_REMOVE) || (kind_in == KIND_SELECT)) && table_empty) ||
                          ((kind_in == KIND_INSERT) && table_full));
    assign clear_last  = (cnt_reg == CNT_W'(CAPACITY - 1));
    assign scan_last   = (cnt_reg == CNT_W'(CAPACITY));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                priority if (accept && (kind_in == KIND_CLEAR))
                begin
                    state_next = ST_CLEAR;
                end
                else if (accept && !quick_resp)
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Memory and picker controls
    always_comb
    begin
        rd_en      = 1'b0;
        rd_addr    = cnt_reg[AW-1:0];
        wr_en      = 1'b0;
        wr_addr    = cnt_reg[AW-1:0];
        wr_used    = 1'b0;
        wr_data_en = 1'b0;
        wr_data    = '{node: id_reg, fcost: f_reg, hcost: h_reg, age: stamp_reg};
        scan_ctl   = '{clr: (state_reg == ST_IDLE), mode: kind_reg};
        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en = 1'b1;
            end
            ST_SCAN:
            begin
                rd_en = !scan_last;
            end
            ST_FINISH:
            begin
                wr_addr = best_idx;
                if ((kind_reg == KIND_INSERT) && best_hit)
                begin
                    wr_en      = 1'b1;
                    wr_used    = 1'b1;
                    wr_data_en = 1'b1;
                end
                else if ((kind_reg == KIND_REMOVE) && best_hit)
                begin
                    wr_en = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // State, slot counter, fill count and insert stamp
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            cnt_reg      <= '0;
            held_reg     <= '0;
            stamp_reg    <= '0;
            clr_resp_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_IDLE)
            begin
                cnt_reg <= '0;
            end
            else if ((state_reg == ST_CLEAR) || (state_reg == ST_SCAN))
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end

            if (accept && (kind_in == KIND_CLEAR))
            begin
                held_reg     <= '0;
                stamp_reg    <= '0;
                clr_resp_reg <= 1'b1;
            end
            else if ((state_reg == ST_CLEAR) && clear_last)
            begin
                clr_resp_reg <= 1'b0;
            end

            if ((state_reg == ST_FINISH) && best_hit)
            begin
                if (kind_reg == KIND_INSERT)
                begin
                    held_reg  <= held_reg + 1'b1;
                    stamp_reg <= stamp_reg + 32'd1;
                end
                else if (kind_reg == KIND_REMOVE)
                begin
                    held_reg <= held_reg - 1'b1;
                end
            end
        end
    end

    // Command payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= kind_in;
            id_reg   <= node_id;
            f_reg    <= f_cost;
            h_reg    <= h_cost;
        end
    end

    // Result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= quick_resp || (state_reg == ST_FINISH) ||
                        ((state_reg == ST_CLEAR) && clear_last && clr_resp_reg);
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (quick_resp)
        begin
            status_reg   <= (kind_in == KIND_INSERT) ? STAT_FULL : STAT_EMPTY;
            node_out_reg <= '0;
            f_out_reg    <= '0;
            h_out_reg    <= '0;
        end
        else if (state_reg == ST_FINISH)
        begin
            node_out_reg <= '0;
            f_out_reg    <= '0;
            h_out_reg    <= '0;
            unique case (kind_reg)
                KIND_INSERT: status_reg <= best_hit ? STAT_OK : STAT_FULL;
                KIND_REMOVE: status_reg <= best_hit ? STAT_OK : STAT_NOT_FOUND;
                KIND_SELECT:
                begin
                    status_reg <= best_hit ? STAT_OK : STAT_EMPTY;
                    if (best_hit)
                    begin
                        node_out_reg <= best_data.node;
                        f_out_reg    <= best_data.fcost;
                        h_out_reg    <= best_data.hcost;
                    end
                end
                default:     status_reg <= STAT_OK;
            endcase
        end
        else if ((state_reg == ST_CLEAR) && clear_last)
        begin
            status_reg   <= STAT_OK;
            node_out_reg <= '0;
            f_out_reg    <= '0;
            h_out_reg    <= '0;
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign found_node   = node_out_reg;
    assign found_f_cost = f_out_reg;
    assign found_h_cost = h_out_reg;
    assign entry_total  = held_reg[6:0];

    // Slot memories
    olmc_store #(
        .CAPACITY (CAPACITY)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_vld     (rd_vld),
        .rd_idx     (rd_idx),
        .rd_used    (rd_used),
        .rd_data    (rd_data),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_used    (wr_used),
        .wr_data_en (wr_data_en),
        .wr_data    (wr_data)
    );

    // Running best candidate over the pass
    olmc_pick #(
        .CAPACITY (CAPACITY)
    ) u_pick (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (scan_ctl),
        .key_id    (id_reg),
        .stamp     (stamp_reg),
        .rd_vld    (rd_vld),
        .rd_idx    (rd_idx),
        .rd_used   (rd_used),
        .rd_data   (rd_data),
        .best_hit  (best_hit),
        .best_idx  (best_idx),
        .best_data (best_data)
    );

    // Fill count never passes the table depth
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= HW'(CAPACITY))
        else $error("fill count above capacity");

    // A clear transfer empties the count and starts the sweep
    a_clear_start: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (kind_in == KIND_CLEAR)) |=> ((state_reg == ST_CLEAR) && table_empty))
        else $error("clear did not start sweep");

    // The write-back cycle always yields exactly one result
    a_finish_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) |=> (done_reg && (state_reg == ST_IDLE)))
        else $error("no result after write-back");

    // No memory write while the pass reads
    a_scan_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> !wr_en)
        else $error("write during scan");

endmodule
